// ===== hw/rtl/aes_pkg.sv =====
// AES-128 package: types, S-box tables, GF(2^8) helpers and round functions.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package aes_pkg;

    localparam int ROUNDS    = 10;
    localparam int RK_DEPTH  = ROUNDS + 1;
    localparam int RK_AW     = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd1;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    localparam logic [RK_AW-1:0] STEP_FIRST = 4'd0;
    localparam logic [RK_AW-1:0] STEP_LAST  = 4'd10;
    localparam logic [7:0]       RCON_INIT  = 8'h01;

    typedef logic [127:0] t_blk;

    typedef struct packed {
        logic             en;
        logic [RK_AW-1:0] addr;
        t_blk             data;
    } t_rk_wr;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    localparam logic [7:0] RSBOX [256] = '{
        8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
        8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
        8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
        8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
        8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
        8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
        8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
        8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
        8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
        8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
        8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
        8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
        8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
        8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
        8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
        8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
        8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
        8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
        8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
        8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
        8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
        8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
        8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
        8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
        8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
        8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
        8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
        8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
        8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
        8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
        8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
        8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
    };

    function automatic logic [7:0] xtime(logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] get_byte(t_blk s, int i);
        get_byte = s[127-8*i -: 8];
    endfunction

    function automatic t_blk byte_sub(t_blk s, logic inv);
        t_blk o;
        o = '0;
        for (int i = 0; i < 16; i++) begin
            o[127-8*i -: 8] = inv ? RSBOX[get_byte(s, i)] : SBOX[get_byte(s, i)];
        end
        byte_sub = o;
    endfunction

    function automatic t_blk shift_rows(t_blk s, logic inv);
        t_blk o;
        o = '0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (inv) begin
                    o[127-8*(r+4*((c+r)%4)) -: 8] = get_byte(s, r + 4*c);
                end else begin
                    o[127-8*(r+4*c) -: 8] = get_byte(s, r + 4*((c+r)%4));
                end
            end
        end
        shift_rows = o;
    endfunction

    function automatic t_blk col_mix(t_blk s, logic inv);
        t_blk       o;
        logic [7:0] a1, a2, a3;
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] a  [4];
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                a[j]  = get_byte(s, 4*c + j);
                x2[j] = xtime(a[j]);
                x4[j] = xtime(x2[j]);
                x8[j] = xtime(x4[j]);
            end
            for (int r = 0; r < 4; r++) begin
                a1 = a[(r+1)%4];
                a2 = a[(r+2)%4];
                a3 = a[(r+3)%4];
                if (inv) begin
                    // 14*a0 ^ 11*a1 ^ 13*a2 ^ 9*a3
                    o[127-8*(4*c+r) -: 8] =
                        (x8[r] ^ x4[r] ^ x2[r]) ^
                        (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a1) ^
                        (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a2) ^
                        (x8[(r+3)%4] ^ a3);
                end else begin
                    o[127-8*(4*c+r) -: 8] = x2[r] ^ (x2[(r+1)%4] ^ a1) ^ a2 ^ a3;
                end
            end
        end
        col_mix = o;
    endfunction

    function automatic t_blk enc_round(t_blk s, t_blk rk, logic last);
        t_blk t;
        t = shift_rows(byte_sub(s, 1'b0), 1'b0);
        if (!last) begin
            t = col_mix(t, 1'b0);
        end
        enc_round = t ^ rk;
    endfunction

    function automatic t_blk dec_round(t_blk s, t_blk rk, logic last);
        t_blk t;
        t = byte_sub(shift_rows(s, 1'b1), 1'b1) ^ rk;
        if (!last) begin
            t = col_mix(t, 1'b1);
        end
        dec_round = t;
    endfunction

    function automatic t_blk next_round_key(t_blk k, logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, rw, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        rw = {w3[23:0], w3[31:24]};
        t  = {SBOX[rw[31:24]] ^ rc, SBOX[rw[23:16]], SBOX[rw[15:8]], SBOX[rw[7:0]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        next_round_key = {w0, w1, w2, w3};
    endfunction

endpackage

// ===== hw/rtl/aes_if.sv =====
// Handshake interfaces for the AES-128 block: input, result and configuration words.
// Depends on aes_pkg for the configuration index width.
`timescale 1ns / 1ps

interface aes_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [63:0] block_high;
    logic [63:0] block_low;
    modport source (output valid, opcode, block_high, block_low, input ready);
    modport sink   (input valid, opcode, block_high, block_low, output ready);
endinterface

interface aes_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_high;
    logic [63:0] result_low;
    modport source (output valid, result_high, result_low, input ready);
    modport sink   (input valid, result_high, result_low, output ready);
endinterface

interface aes_cfg_if import aes_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/aes_kexp.sv =====
// Key registers and round key expansion: one round key per cycle into the key store.
// Depends on aes_pkg.
`timescale 1ns / 1ps

module aes_kexp import aes_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    output t_rk_wr               o_wr,
    output logic                 o_busy
);

    logic [63:0]      r_key_high, r_key_low;
    t_blk             r_rk;
    logic [7:0]       r_rc;
    logic [RK_AW-1:0] r_idx;
    logic             r_busy;
    logic             w_start;

    assign w_start = i_cfg_we && (i_cfg_index == CFG_KEY_HIGH || i_cfg_index == CFG_KEY_LOW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_rk       <= '0;
            r_rc       <= RCON_INIT;
            r_idx      <= STEP_FIRST;
            r_busy     <= 1'b1;
        end else if (w_start) begin
            if (i_cfg_index == CFG_KEY_HIGH) begin
                r_key_high <= i_cfg_data;
                r_rk       <= {i_cfg_data, r_key_low};
            end else begin
                r_key_low <= i_cfg_data;
                r_rk      <= {r_key_high, i_cfg_data};
            end
            r_rc   <= RCON_INIT;
            r_idx  <= STEP_FIRST;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_rk  <= next_round_key(r_rk, r_rc);
            r_rc  <= xtime(r_rc);
            r_idx <= r_idx + 1'b1;
            if (r_idx == STEP_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_wr.en   = r_busy;
    assign o_wr.addr = r_idx;
    assign o_wr.data = r_rk;
    assign o_busy    = r_busy;

endmodule

// ===== hw/rtl/aes_rk_mem.sv =====
// Round key store: two 64-bit banks of eleven words, one write and one registered read.
// Depends on aes_pkg.
`timescale 1ns / 1ps

module aes_rk_mem import aes_pkg::*; (
    input  logic             i_clk,
    input  t_rk_wr           i_wr,
    input  logic [RK_AW-1:0] i_rd_addr,
    output t_blk             o_rd_data
);

    logic [63:0] r_mem_hi [RK_DEPTH];
    logic [63:0] r_mem_lo [RK_DEPTH];
    logic [63:0] r_rd_hi, r_rd_lo;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem_hi[i_wr.addr] <= i_wr.data[127:64];
            r_mem_lo[i_wr.addr] <= i_wr.data[63:0];
        end
        r_rd_hi <= r_mem_hi[i_rd_addr];
        r_rd_lo <= r_mem_lo[i_rd_addr];
    end

    assign o_rd_data = {r_rd_hi, r_rd_lo};

endmodule

// ===== hw/rtl/aes_core.sv =====
// Round datapath: one round per cycle, the last round held while an older result waits;
// each round key read the cycle before its round. Depends on aes_pkg and aes_if.
`timescale 1ns / 1ps

module aes_core import aes_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_kexp_busy,
    aes_in_if.sink           i_in,
    aes_out_if.source        o_out,
    output logic [RK_AW-1:0] o_rd_addr,
    input  t_blk             i_rk,
    output logic             o_busy
);

    logic             r_busy, r_dec, r_out_valid;
    logic [RK_AW-1:0] r_step;
    t_blk             r_state, r_res, n_state;
    logic             w_accept, w_advance, w_last;
    logic [RK_AW-1:0] w_nstep;

    assign i_in.ready = !r_busy && !i_kexp_busy;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_last     = (r_step == STEP_LAST);
    assign w_advance  = r_busy && !(w_last && r_out_valid && !o_out.ready);
    assign w_nstep    = (w_advance && !w_last) ? r_step + 1'b1 : r_step;

    always_comb begin
        if (w_accept) begin
            o_rd_addr = (i_in.opcode == OP_DECRYPT) ? STEP_LAST : STEP_FIRST;
        end else begin
            o_rd_addr = r_dec ? STEP_LAST - w_nstep : w_nstep;
        end
    end

    always_comb begin
        if (r_step == STEP_FIRST) begin
            n_state = r_state ^ i_rk;
        end else if (r_dec) begin
            n_state = dec_round(r_state, i_rk, w_last);
        end else begin
            n_state = enc_round(r_state, i_rk, w_last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_step      <= STEP_FIRST;
            r_dec       <= OP_ENCRYPT;
        end else begin
            if (w_advance && w_last) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_accept) begin
                r_busy  <= 1'b1;
                r_step  <= STEP_FIRST;
                r_dec   <= i_in.opcode;
                r_state <= {i_in.block_high, i_in.block_low};
            end else if (w_advance) begin
                r_state <= n_state;
                r_step  <= w_nstep;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_res  <= n_state;
                end
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.result_high = r_res[127:64];
    assign o_out.result_low  = r_res[63:0];
    assign o_busy            = r_busy;

endmodule

// ===== hw/rtl/aes128_block_cipher.sv =====
// AES-128 block cipher, top level: key expansion, round key store and round datapath.
// Depends on aes_pkg, aes_if, aes_kexp, aes_rk_mem and aes_core.
`timescale 1ns / 1ps

// A block is accepted when the cipher is idle; it runs one step per round key read
// from the key store (initial key addition plus ten rounds), and no new block is
// taken until its last round is done. The result sits in an output register and the
// next block may be taken while it waits. Writing key_high or key_low re-expands the
// key, one round key per cycle, and the cipher takes no block until that pass is
// done; the same pass runs after reset. A key word is taken only while no block is
// in flight and no block word is offered.

module aes128_block_cipher import aes_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    aes_in_if.sink    i_in,
    aes_out_if.source o_out,
    aes_cfg_if.sink   i_cfg
);

    t_rk_wr           w_wr;
    logic             w_kexp_busy, w_core_busy;
    logic [RK_AW-1:0] w_rd_addr;
    t_blk             w_rk;

    assign i_cfg.ready = !w_kexp_busy && !w_core_busy && !i_in.valid;

    aes_kexp u_kexp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg.valid && i_cfg.ready),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_wr        (w_wr),
        .o_busy      (w_kexp_busy)
    );

    aes_rk_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rk)
    );

    aes_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_kexp_busy (w_kexp_busy),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_rd_addr   (w_rd_addr),
        .i_rk        (w_rk),
        .o_busy      (w_core_busy)
    );

endmodule

// ===== hw/rtl/aes_chk.sv =====
// Port-level checker for the AES-128 block, bound to the top level.
// Depends on aes_pkg.
`timescale 1ns / 1ps

module aes_chk import aes_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [63:0]          i_out_high,
    input logic [63:0]          i_out_low,
    input logic                 i_cfg_valid,
    input logic                 i_cfg_ready,
    input logic [CFG_IDX_W-1:0] i_cfg_index
);

    logic w_in_acc, w_key_acc;
    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_key_acc = i_cfg_valid && i_cfg_ready &&
                       (i_cfg_index == CFG_KEY_HIGH || i_cfg_index == CFG_KEY_LOW);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_high) && $stable(i_out_low))
        else $error("result word dropped or changed while stalled");

    a_one_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !i_in_ready && !i_cfg_ready)
        else $error("ready while a block is in flight");

    a_rekey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_key_acc |=> !i_in_ready && !i_cfg_ready)
        else $error("ready during key expansion");

    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> ##1 !$rose(i_out_valid))
        else $error("result too early");

endmodule

bind aes128_block_cipher aes_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_high  (o_out.result_high),
    .i_out_low   (o_out.result_low),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready),
    .i_cfg_index (i_cfg.index)
);

// ===== tb/sv/aes_cipher_checker.sv =====
// Checker for the AES-128 block cipher: watches key, block and result words,
// predicts each result with its own AES model and compares. Depends on aes_pkg, aes_if.
`timescale 1ns / 1ps

module aes_cipher_checker import aes_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    aes_in_if     i_in,
    aes_out_if    i_out,
    aes_cfg_if    i_cfg,
    output int    o_fail_count,
    output int    o_pending
);

    logic [7:0]   fwd_tab [256];
    logic [7:0]   inv_tab [256];
    logic [63:0]  key_hi_q;
    logic [63:0]  key_lo_q;
    logic [127:0] rkeys [11];
    logic [127:0] expected_blocks [$];

    function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[0]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            b = b >> 1;
        end
        return p;
    endfunction

    function automatic logic [7:0] rotl(logic [7:0] v, int n);
        return (v << n) | (v >> (8 - n));
    endfunction

    task automatic build_boxes();
        logic [7:0] iv;
        for (int v = 0; v < 256; v++) begin
            iv = 8'h01;
            for (int i = 0; i < 254; i++) iv = gmul(iv, v[7:0]);
            if (v == 0) iv = 8'h00;
            fwd_tab[v] = iv ^ rotl(iv, 1) ^ rotl(iv, 2) ^ rotl(iv, 3) ^ rotl(iv, 4) ^ 8'h63;
        end
        for (int v = 0; v < 256; v++) inv_tab[fwd_tab[v]] = v[7:0];
    endtask

    task automatic build_round_keys();
        logic [31:0] w [44];
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        w[0] = key_hi_q[63:32]; w[1] = key_hi_q[31:0];
        w[2] = key_lo_q[63:32]; w[3] = key_lo_q[31:0];
        for (int i = 4; i < 44; i++) begin
            t = w[i-1];
            if (i % 4 == 0) begin
                t = {t[23:0], t[31:24]};
                t = {fwd_tab[t[31:24]] ^ rc, fwd_tab[t[23:16]], fwd_tab[t[15:8]],
                     fwd_tab[t[7:0]]};
                rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int r = 0; r < 11; r++) rkeys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endtask

    function automatic logic [127:0] cipher_block(logic dec, logic [127:0] blk);
        logic [7:0] s [16];
        logic [7:0] o [16];
        logic [7:0] a [4];
        logic [7:0] fm [4];
        logic [7:0] im [4];
        logic [127:0] res;
        fm = '{8'd2, 8'd3, 8'd1, 8'd1};
        im = '{8'd14, 8'd11, 8'd13, 8'd9};
        for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
        for (int step = 0; step <= ROUNDS; step++) begin
            if (step > 0) begin
                o = s;
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++)
                        if (dec) s[r+4*((c+r)%4)] = o[r+4*c];
                        else s[r+4*c] = o[r+4*((c+r)%4)];
                for (int i = 0; i < 16; i++) s[i] = dec ? inv_tab[s[i]] : fwd_tab[s[i]];
                if (!dec && step != ROUNDS) begin
                    for (int c = 0; c < 4; c++) begin
                        for (int j = 0; j < 4; j++) a[j] = s[4*c+j];
                        for (int r = 0; r < 4; r++) begin
                            s[4*c+r] = 8'h00;
                            for (int j = 0; j < 4; j++) s[4*c+r] ^= gmul(fm[(j-r+4)%4], a[j]);
                        end
                    end
                end
            end
            for (int i = 0; i < 16; i++)
                s[i] ^= rkeys[dec ? ROUNDS - step : step][127-8*i -: 8];
            if (dec && step > 0 && step != ROUNDS) begin
                for (int c = 0; c < 4; c++) begin
                    for (int j = 0; j < 4; j++) a[j] = s[4*c+j];
                    for (int r = 0; r < 4; r++) begin
                        s[4*c+r] = 8'h00;
                        for (int j = 0; j < 4; j++) s[4*c+r] ^= gmul(im[(j-r+4)%4], a[j]);
                    end
                end
            end
        end
        for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
        return res;
    endfunction

    initial begin
        o_fail_count = 0;
        build_boxes();
        key_hi_q = '0;
        key_lo_q = '0;
        build_round_keys();
    end

    assign o_pending = expected_blocks.size();

    always @(posedge i_clk) begin
        logic [127:0] exp_blk;
        if (i_rst_n) begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_KEY_HIGH) begin
                    key_hi_q = i_cfg.data;
                    build_round_keys();
                end else if (i_cfg.index == CFG_KEY_LOW) begin
                    key_lo_q = i_cfg.data;
                    build_round_keys();
                end
            end
            if (i_in.valid && i_in.ready)
                expected_blocks.push_back(cipher_block(i_in.opcode,
                                                       {i_in.block_high, i_in.block_low}));
            if (i_out.valid && i_out.ready) begin
                if (expected_blocks.size() == 0) begin
                    $display("%0t: unexpected result %h_%h", $time,
                             i_out.result_high, i_out.result_low);
                    o_fail_count++;
                end else begin
                    exp_blk = expected_blocks.pop_front();
                    if (i_out.result_high !== exp_blk[127:64]) begin
                        $display("%0t: result_high expected %h actual %h", $time,
                                 exp_blk[127:64], i_out.result_high);
                        o_fail_count++;
                    end
                    if (i_out.result_low !== exp_blk[63:0]) begin
                        $display("%0t: result_low expected %h actual %h", $time,
                                 exp_blk[63:0], i_out.result_low);
                        o_fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for aes128_block_cipher: clock, reset, key and block stimulus,
// result back-pressure and verdict. Depends on aes_pkg, aes_if, aes_cipher_checker.
`timescale 1ns / 1ps

module tb;
    import aes_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 40;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    bit   hold_ready = 1'b0;

    aes_in_if  in_ch ();
    aes_out_if out_ch ();
    aes_cfg_if cfg_ch ();

    aes128_block_cipher u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    aes_cipher_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_ENCRYPT;
        in_ch.block_high = '0;
        in_ch.block_low = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_KEY_HIGH;
        cfg_ch.data = '0;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            default: v = {$urandom(), $urandom()};
        endcase
        return v;
    endfunction

    // result back-pressure
    always @(posedge i_clk) begin
        if (hold_ready || $urandom_range(0, 99) < 30) out_ch.ready <= 1'b0;
        else out_ch.ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL aes128_block_cipher");
            $finish;
        end
    end

    task automatic send_block(logic op, logic [63:0] hi, logic [63:0] lo);
        in_ch.valid <= 1'b1;
        in_ch.opcode <= op;
        in_ch.block_high <= hi;
        in_ch.block_low <= lo;
        do @(posedge i_clk); while (!in_ch.ready);
        repeat (gap_len()) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic end_blocks();
        in_ch.valid <= 1'b0;
    endtask

    task automatic wait_drain();
        end_blocks();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_key(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_blocks(int count);
        for (int n = 0; n < count; n++)
            send_block(1'($urandom_range(0, 1)), rand64(), rand64());
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset key, then FIPS-197 vectors and extremes
        send_block(OP_ENCRYPT, '0, '0);
        send_block(OP_DECRYPT, '0, '0);
        send_block(OP_ENCRYPT, '1, '1);
        send_block(OP_DECRYPT, '1, '1);
        wait_drain();
        write_key(CFG_KEY_HIGH, 64'h0001020304050607);
        write_key(CFG_KEY_LOW, 64'h08090a0b0c0d0e0f);
        send_block(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(OP_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        send_block(OP_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001);
        send_block(OP_DECRYPT, 64'h0000000000000001, 64'h8000000000000000);
        wait_drain();
        // half a key changed: new high with old low
        write_key(CFG_KEY_HIGH, '1);
        send_block(OP_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
        send_block(OP_DECRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
        wait_drain();
        write_key(CFG_SPARE_A, 64'hdeadbeefdeadbeef);
        write_key(CFG_SPARE_B, 64'h0123456789abcdef);
        write_key(CFG_KEY_LOW, '1);
        send_block(OP_ENCRYPT, '0, '1);
        send_block(OP_DECRYPT, '1, '0);
        // sender holds off until everything has come back
        wait_drain();
        hold_ready = 1'b1;
        send_block(OP_ENCRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        send_block(OP_DECRYPT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        end_blocks();
        repeat (30) @(posedge i_clk);
        hold_ready = 1'b0;
        wait_drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_key(CFG_KEY_HIGH, rand64());
            write_key(CFG_KEY_LOW, rand64());
            random_blocks(90);
            wait_drain();
        end
        write_key(CFG_KEY_HIGH, '0);
        write_key(CFG_KEY_LOW, '0);
        random_blocks(10);
        wait_drain();

        if (fail_count == 0) begin
            $display("PASS aes128_block_cipher");
        end else begin
            $display("FAIL aes128_block_cipher");
        end
        $finish;
    end

endmodule
